@@ hw/rtl/mca_pkg.sv @@
// Shared types, constants and helper functions of the 4x4 column matrix ALU.
// Used by the channel interfaces, the column cells, the serializer and the top level.
// Depends on nothing.
package mca_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int AccW     = ProdW + 2;
  localparam int NumCols  = 4;
  localparam int ColW     = 2;
  localparam int FuncW    = 3;

  typedef enum logic [FuncW-1:0] {
    FuncLoad  = 3'd0,
    FuncAdd   = 3'd1,
    FuncSub   = 3'd2,
    FuncScale = 3'd3,
    FuncXform = 3'd4,
    FuncAddIp = 3'd5,
    FuncSubIp = 3'd6
  } func_e;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef data_t [NumCols-1:0]     vec_t;

  // Fixed-point 1.0 and the unit vector (1, 0, 0, 0).
  localparam data_t QOne    = data_t'(64'd1 << FracBits);
  localparam vec_t  UnitVec = {{((NumCols - 1) * DataW){1'b0}}, QOne};

  // Payload that travels down the row of column cells.
  typedef struct packed {
    func_e                    func;
    logic [ColW-1:0]          col;
    vec_t                     op;
    acc_t [NumCols-1:0]       acc;
    vec_t [NumCols-1:0]       res;
    logic [NumCols-1:0]       sat;
  } chain_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } cell_ctl_t;

  typedef struct packed {
    logic vld_a;
    logic vld_b;
  } cell_sts_t;

  typedef struct packed {
    data_t val;
    logic  sat;
  } clamp_t;

  // Clamps a wide signed value to the 32-bit range and flags when it had to.
  function automatic clamp_t sat_clamp(acc_t v);
    clamp_t c;
    if (v[AccW-1:DataW-1] == {(AccW - DataW + 1){v[AccW-1]}}) begin
      c.val = v[DataW-1:0];
      c.sat = 1'b0;
    end else begin
      c.sat = 1'b1;
      c.val = v[AccW-1] ? {1'b1, {(DataW - 1){1'b0}}} : {1'b0, {(DataW - 1){1'b1}}};
    end
    return c;
  endfunction

  // Element j of the result is element j + k of the input, modulo four.
  function automatic vec_t vec_rot(vec_t v, logic [ColW-1:0] k);
    vec_t o;
    logic [ColW-1:0] s;
    for (int j = 0; j < NumCols; j++) begin
      s    = ColW'(j) + k;
      o[j] = v[s];
    end
    return o;
  endfunction

  // Inverse of vec_rot.
  function automatic vec_t vec_unrot(vec_t v, logic [ColW-1:0] k);
    vec_t o;
    logic [ColW-1:0] s;
    for (int j = 0; j < NumCols; j++) begin
      s    = ColW'(j) - k;
      o[j] = v[s];
    end
    return o;
  endfunction

endpackage

@@ hw/rtl/mca_if.sv @@
// Valid/ready channel interfaces for the input items and the result items.
// Depends on mca_pkg for field widths.
interface mca_in_if;
  logic                               valid;
  logic                               ready;
  logic [mca_pkg::FuncW-1:0]          func;
  logic [mca_pkg::ColW-1:0]           col;
  logic signed [mca_pkg::DataW-1:0]   operand_0;
  logic signed [mca_pkg::DataW-1:0]   operand_1;
  logic signed [mca_pkg::DataW-1:0]   operand_2;
  logic signed [mca_pkg::DataW-1:0]   operand_3;

  modport source (output valid, func, col, operand_0, operand_1, operand_2, operand_3,
                  input ready);
  modport sink (input valid, func, col, operand_0, operand_1, operand_2, operand_3,
                output ready);
endinterface

interface mca_out_if;
  logic                               valid;
  logic                               ready;
  logic [mca_pkg::ColW-1:0]           out_col;
  logic signed [mca_pkg::DataW-1:0]   result_0;
  logic signed [mca_pkg::DataW-1:0]   result_1;
  logic signed [mca_pkg::DataW-1:0]   result_2;
  logic signed [mca_pkg::DataW-1:0]   result_3;
  logic                               saturated;
  logic                               last;

  modport source (output valid, out_col, result_0, result_1, result_2, result_3,
                  saturated, last, input ready);
  modport sink (input valid, out_col, result_0, result_1, result_2, result_3,
                saturated, last, output ready);
endinterface

@@ hw/rtl/mca_cell.sv @@
// One column cell: holds one matrix column and runs two pipeline stages of the row.
// Depends on mca_pkg.
module mca_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [mca_pkg::ColW-1:0]    idx_i,
  input  mca_pkg::cell_ctl_t          ctl_i,
  input  logic                        vld_i,
  input  mca_pkg::chain_t             item_i,
  output mca_pkg::cell_sts_t          sts_o,
  output mca_pkg::chain_t             item_o
);

  // The column is kept rotated by the cell index so that every cell resets to (1, 0, 0, 0).
  mca_pkg::vec_t   store_q, store_d;
  mca_pkg::vec_t   a_col;
  mca_pkg::data_t  mop;
  logic            hit;
  logic            vld_a_q, vld_b_q;
  mca_pkg::chain_t pa_q, pa_d, pb_q, pb_d;
  mca_pkg::prod_t [mca_pkg::NumCols-1:0] prod_q, prod_d;
  mca_pkg::acc_t   sum_a, sh_b;
  mca_pkg::clamp_t cl_a, cl_b;
  logic            sat_a, sat_b;

  // Stage A: column access, load, add or subtract, and the four products.
  always_comb begin
    a_col   = mca_pkg::vec_unrot(store_q, idx_i);
    hit     = (item_i.col == idx_i);
    pa_d    = item_i;
    store_d = store_q;
    sat_a   = 1'b0;
    sum_a   = '0;
    cl_a    = '0;
    mop     = (item_i.func == mca_pkg::FuncScale) ? item_i.op[0] : item_i.op[idx_i];
    for (int r = 0; r < mca_pkg::NumCols; r++) begin
      prod_d[r] = mca_pkg::prod_t'(a_col[r]) * mca_pkg::prod_t'(mop);
    end
    unique case (item_i.func)
      mca_pkg::FuncLoad: begin
        if (hit) begin
          store_d = mca_pkg::vec_rot(item_i.op, idx_i);
        end
      end
      mca_pkg::FuncAdd, mca_pkg::FuncSub, mca_pkg::FuncAddIp, mca_pkg::FuncSubIp: begin
        if (hit) begin
          for (int r = 0; r < mca_pkg::NumCols; r++) begin
            if (item_i.func == mca_pkg::FuncAdd || item_i.func == mca_pkg::FuncAddIp) begin
              sum_a = mca_pkg::acc_t'(a_col[r]) + mca_pkg::acc_t'(item_i.op[r]);
            end else begin
              sum_a = mca_pkg::acc_t'(a_col[r]) - mca_pkg::acc_t'(item_i.op[r]);
            end
            cl_a                 = mca_pkg::sat_clamp(sum_a);
            pa_d.res[idx_i][r]   = cl_a.val;
            sat_a                = sat_a | cl_a.sat;
          end
          pa_d.sat[idx_i] = sat_a;
          if (item_i.func == mca_pkg::FuncAddIp || item_i.func == mca_pkg::FuncSubIp) begin
            store_d = mca_pkg::vec_rot(pa_d.res[idx_i], idx_i);
          end
        end
      end
      default: ;
    endcase
  end

  // Stage B: scale results for this column, or this column's share of the transform sum.
  always_comb begin
    pb_d  = pa_q;
    sat_b = 1'b0;
    sh_b  = '0;
    cl_b  = '0;
    unique case (pa_q.func)
      mca_pkg::FuncScale: begin
        for (int r = 0; r < mca_pkg::NumCols; r++) begin
          sh_b = $signed({{(mca_pkg::AccW - mca_pkg::ProdW){prod_q[r][mca_pkg::ProdW-1]}},
                          prod_q[r]}) >>> mca_pkg::FracBits;
          cl_b               = mca_pkg::sat_clamp(sh_b);
          pb_d.res[idx_i][r] = cl_b.val;
          sat_b              = sat_b | cl_b.sat;
        end
        pb_d.sat[idx_i] = sat_b;
      end
      mca_pkg::FuncXform: begin
        for (int r = 0; r < mca_pkg::NumCols; r++) begin
          pb_d.acc[r] = pa_q.acc[r]
                      + $signed({{(mca_pkg::AccW - mca_pkg::ProdW){prod_q[r][mca_pkg::ProdW-1]}},
                                 prod_q[r]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      store_q <= mca_pkg::UnitVec;
    end else begin
      if (ctl_i.en_a) begin
        vld_a_q <= vld_i;
      end
      if (ctl_i.en_a && vld_i) begin
        store_q <= store_d;
      end
      if (ctl_i.en_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en_a) begin
      pa_q   <= pa_d;
      prod_q <= prod_d;
    end
    if (ctl_i.en_b) begin
      pb_q <= pb_d;
    end
  end

  assign sts_o.vld_a = vld_a_q;
  assign sts_o.vld_b = vld_b_q;
  assign item_o      = pb_q;

endmodule

@@ hw/rtl/mca_ser.sv @@
// Output serializer: turns one finished item into zero, one or four result items.
// Depends on mca_pkg and mca_out_if.
module mca_ser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  mca_pkg::chain_t      item_i,
  output logic                 take_o,
  mca_out_if.source            out_o
);

  logic                                held_q;
  logic [mca_pkg::ColW-1:0]            idx_q, last_q, last_d, base_q, base_d;
  mca_pkg::vec_t [mca_pkg::NumCols-1:0] slots_q, slots_d;
  logic [mca_pkg::NumCols-1:0]         sats_q, sats_d;
  logic                                produce, fin, sat_x;
  mca_pkg::clamp_t                     cl;

  always_comb begin
    slots_d = item_i.res;
    sats_d  = item_i.sat;
    base_d  = '0;
    last_d  = '0;
    produce = 1'b0;
    sat_x   = 1'b0;
    cl      = '0;
    unique case (item_i.func)
      mca_pkg::FuncAdd, mca_pkg::FuncSub, mca_pkg::FuncAddIp, mca_pkg::FuncSubIp: begin
        produce    = 1'b1;
        slots_d[0] = item_i.res[item_i.col];
        sats_d[0]  = item_i.sat[item_i.col];
        base_d     = item_i.col;
      end
      mca_pkg::FuncScale: begin
        produce = 1'b1;
        last_d  = mca_pkg::ColW'(mca_pkg::NumCols - 1);
      end
      mca_pkg::FuncXform: begin
        produce = 1'b1;
        for (int r = 0; r < mca_pkg::NumCols; r++) begin
          cl            = mca_pkg::sat_clamp(item_i.acc[r] >>> mca_pkg::FracBits);
          slots_d[0][r] = cl.val;
          sat_x         = sat_x | cl.sat;
        end
        sats_d[0] = sat_x;
      end
      default: ;
    endcase
  end

  assign fin    = (idx_q == last_q);
  assign take_o = !held_q || (out_o.ready && fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      idx_q  <= '0;
    end else if (take_o) begin
      held_q <= vld_i && produce;
      idx_q  <= '0;
    end else if (out_o.ready) begin
      idx_q <= idx_q + mca_pkg::ColW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && vld_i) begin
      slots_q <= slots_d;
      sats_q  <= sats_d;
      base_q  <= base_d;
      last_q  <= last_d;
    end
  end

  assign out_o.valid     = held_q;
  assign out_o.out_col   = base_q + idx_q;
  assign out_o.result_0  = slots_q[idx_q][0];
  assign out_o.result_1  = slots_q[idx_q][1];
  assign out_o.result_2  = slots_q[idx_q][2];
  assign out_o.result_3  = slots_q[idx_q][3];
  assign out_o.saturated = sats_q[idx_q];
  assign out_o.last      = fin;

endmodule

@@ hw/rtl/mat4_column_alu.sv @@
// A result item passes two register stages in each of the four column cells, then the
// output register of the serializer. Throughput: one input item per cycle while results
// are taken at the output; a scale item holds the output for its four result items, load
// and the unused selector give no result. Reset is asynchronous and active low: it empties
// the pipeline and sets the matrix to the identity at once, with no clearing pass.
// Depends on mca_pkg, mca_if, mca_cell and mca_ser.
module mat4_column_alu (
  input  logic      clk_i,
  input  logic      rst_ni,
  mca_in_if.sink    in_i,
  mca_out_if.source out_o
);

  // The matrix is spread over a row of four cells; cell k owns column k. Every item walks
  // through all cells in order, so each cell sees reads and writes of its column in item
  // order and no forwarding is needed. A transform sum is built up cell by cell in the
  // item's accumulators and floored and clamped once at the end of the row.

  localparam int NumStages = 2 * mca_pkg::NumCols;

  mca_pkg::chain_t   in_item;
  mca_pkg::chain_t   cell_in  [mca_pkg::NumCols];
  mca_pkg::chain_t   cell_out [mca_pkg::NumCols];
  logic              cell_vin [mca_pkg::NumCols];
  mca_pkg::cell_sts_t sts     [mca_pkg::NumCols];
  mca_pkg::cell_ctl_t ctl     [mca_pkg::NumCols];
  logic [NumStages-1:0] stage_vld;
  logic [NumStages:0]   en;
  logic                 ser_take;

  always_comb begin
    in_item      = '0;
    in_item.func = mca_pkg::func_e'(in_i.func);
    in_item.col  = in_i.col;
    in_item.op   = {in_i.operand_3, in_i.operand_2, in_i.operand_1, in_i.operand_0};
  end

  // Chain the cells; the first one takes the input channel.
  always_comb begin
    cell_vin[0] = in_i.valid;
    cell_in[0]  = in_item;
    for (int k = 1; k < mca_pkg::NumCols; k++) begin
      cell_vin[k] = sts[k-1].vld_b;
      cell_in[k]  = cell_out[k-1];
    end
  end

  // A stage loads when it is empty or when the stage after it moves on, so bubbles
  // close up and input is taken while finished results wait at the output.
  always_comb begin
    for (int k = 0; k < mca_pkg::NumCols; k++) begin
      stage_vld[2*k]   = sts[k].vld_a;
      stage_vld[2*k+1] = sts[k].vld_b;
    end
    en[NumStages] = ser_take;
    for (int s = NumStages - 1; s >= 0; s--) begin
      en[s] = !stage_vld[s] || en[s+1];
    end
    for (int k = 0; k < mca_pkg::NumCols; k++) begin
      ctl[k].en_a = en[2*k];
      ctl[k].en_b = en[2*k+1];
    end
  end

  assign in_i.ready = en[0];

  for (genvar k = 0; k < mca_pkg::NumCols; k++) begin : g_cell
    mca_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (mca_pkg::ColW'(k)),
      .ctl_i  (ctl[k]),
      .vld_i  (cell_vin[k]),
      .item_i (cell_in[k]),
      .sts_o  (sts[k]),
      .item_o (cell_out[k])
    );
  end

  mca_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sts[mca_pkg::NumCols-1].vld_b),
    .item_i (cell_out[mca_pkg::NumCols-1]),
    .take_o (ser_take),
    .out_o  (out_o)
  );

endmodule
